// File: src/ocov_pkg.sv
// Shared types and constants for the online covariance accumulator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ocov_pkg;

  // Sample counter width and fraction bits of the means.
  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Fixed field widths of the ports.
  localparam int SAMPLE_W  = 16;
  localparam int MEAN_W    = 32;
  localparam int ACC_W     = 64;
  localparam int SPREAD_W  = 63;
  localparam int CNT_OUT_W = 32;

  // Derived datapath widths.
  localparam int XS_W       = SAMPLE_W + FRAC_BITS;
  localparam int MAG_W      = (XS_W > MEAN_W) ? XS_W : MEAN_W;
  localparam int DIFF_W     = MAG_W + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int SUM_W      = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;
  localparam int CNT_WIDE_W = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

  // Multiply-phase step counter width and the value of its last step.
  localparam int MUL_CNT_W = 2;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(3);

  // Input request: one sample pair.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
  } in_t;

  // Result request: the updated running statistics.
  typedef struct packed {
    logic        [CNT_OUT_W-1:0] sample_count;
    logic signed [MEAN_W-1:0]    mean_of_x;
    logic signed [MEAN_W-1:0]    mean_of_y;
    logic signed [ACC_W-1:0]     cross_moment;
    logic        [SPREAD_W-1:0]  spread_of_x;
    logic        [SPREAD_W-1:0]  spread_of_y;
  } out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MEAN,
    ST_MUL,
    ST_COMMIT
  } state_t;

  // Which moment a multiply or accumulate step works on.
  typedef enum logic [1:0] {
    SEL_CROSS,
    SEL_SPX,
    SEL_SPY
  } mom_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     mean_load;
    logic     mul_en;
    mom_sel_t mul_sel;
    logic     acc_en;
    mom_sel_t acc_sel;
    logic     commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

// File: src/online_covariance_accumulator.sv
// Online covariance accumulator: takes one signed 16-bit (x, y) pair per request
// and returns the updated Welford statistics: the saturating count, the Q16.16
// means of x and y, the Q32.32 cross co-moment and unsigned Q31.32 second moments.
// Each mean moves by its deviation divided by the new count, truncated toward zero.
// Requests are handled one at a time; each passes through the two radix-2 dividers,
// which produce one quotient bit per cycle, and then through the three products of
// one shared 32x32 multiplier. The next request is accepted while a result
// waits at the output, and is held at commit until that result is taken.
// Depends on ocov_pkg, ocov_ctrl, ocov_dp and ocov_div.
`default_nettype none

module online_covariance_accumulator import ocov_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  cmd_t  cmd;
  stat_t stat;

  ocov_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ocov_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: src/ocov_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ocov_pkg for the operand widths.
`default_nettype none

module ocov_div import ocov_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [MAG_W-1:0]      dividend,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output logic      [MAG_W-1:0]      quotient,
  output logic                       busy
);

  logic                  busy_r;
  logic [DIV_CNT_W-1:0]  step_r;
  logic [MAG_W-1:0]      quo_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[MAG_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= DIV_CNT_W'(MAG_W);
    end else if (busy_r) begin
      step_r <= step_r - DIV_CNT_W'(1);
      if (step_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient and remainder registers; the quotient shifts in from the right.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_r <= {quo_r[MAG_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;

endmodule

`default_nettype wire

// File: src/ocov_dp.sv
// Datapath: running statistics, two dividers, shared multiplier and
// saturating accumulator. Depends on ocov_pkg and ocov_div.
`default_nettype none

module ocov_dp import ocov_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output stat_t     stat,
  output out_t      out_data
);

  localparam int MSUM_W = DIFF_W + 1;
  localparam logic signed [MSUM_W-1:0] MEAN_HI =
    $signed({{(MSUM_W-MEAN_W+1){1'b0}}, {(MEAN_W-1){1'b1}}});
  localparam logic signed [MSUM_W-1:0] MEAN_LO =
    $signed({{(MSUM_W-MEAN_W+1){1'b1}}, {(MEAN_W-1){1'b0}}});
  localparam logic signed [SUM_W-1:0] ACC_HI =
    $signed({{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_LO =
    $signed({{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}});

  function automatic logic signed [MEAN_W-1:0] clamp_mean(
    input logic signed [MSUM_W-1:0] v);
    logic signed [MEAN_W-1:0] r;
    if (v > MEAN_HI) begin
      r = MEAN_HI[MEAN_W-1:0];
    end else if (v < MEAN_LO) begin
      r = MEAN_LO[MEAN_W-1:0];
    end else begin
      r = v[MEAN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_acc(
    input logic signed [SUM_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > ACC_HI) begin
      r = ACC_HI[ACC_W-1:0];
    end else if (v < ACC_LO) begin
      r = ACC_LO[ACC_W-1:0];
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // Committed statistics.
  logic        [COUNT_BITS-1:0] count_r;
  logic signed [MEAN_W-1:0]     mean_x_r, mean_y_r;
  logic signed [ACC_W-1:0]      cross_r;
  logic        [SPREAD_W-1:0]   spread_x_r, spread_y_r;

  // Per-request working registers.
  logic signed [XS_W-1:0]     xs_r, ys_r;
  logic signed [DIFF_W-1:0]   dx_r, dy_r;
  logic signed [MEAN_W-1:0]   nmx_r, nmy_r;
  logic        [PROD_W-1:0]   prod_r;
  logic                       neg_r;
  logic signed [ACC_W-1:0]    ncross_r;
  logic        [SPREAD_W-1:0] nspx_r, nspy_r;

  logic signed [XS_W-1:0]     xs_in, ys_in;
  logic signed [DIFF_W-1:0]   dx_in, dy_in;
  logic        [COUNT_BITS-1:0] count_new;
  logic signed [DIFF_W-1:0]   dx_abs, dy_abs;
  logic        [MAG_W-1:0]    qx, qy;
  logic                       busy_x, busy_y;
  logic signed [MSUM_W-1:0]   qx_w, qy_w, qx_s, qy_s, sum_x, sum_y;
  logic signed [DIFF_W-1:0]   a_op, b_op, a_abs, b_abs;
  logic        [MAG_W-1:0]    a_mag, b_mag;
  logic        [PROD_W-1:0]   prod_w;
  logic signed [ACC_W-1:0]    old_acc, acc_sat;
  logic signed [SUM_W-1:0]    prod_ext, acc_sum;
  logic        [SPREAD_W-1:0] spread_new;
  logic        [CNT_WIDE_W-1:0] cnt_wide;

  // Scale the samples and form the deviations from the old means.
  always_comb begin
    xs_in = $signed({in_data.sample_x, {FRAC_BITS{1'b0}}});
    ys_in = $signed({in_data.sample_y, {FRAC_BITS{1'b0}}});
    dx_in = DIFF_W'(xs_in) - DIFF_W'(mean_x_r);
    dy_in = DIFF_W'(ys_in) - DIFF_W'(mean_y_r);
  end

  // The count saturates at its all-ones value.
  assign count_new = (count_r == {COUNT_BITS{1'b1}}) ? count_r
                                                     : count_r + COUNT_BITS'(1);

  // Deviation magnitudes feed the dividers; the sign is applied afterwards.
  assign dx_abs = dx_r[DIFF_W-1] ? -dx_r : dx_r;
  assign dy_abs = dy_r[DIFF_W-1] ? -dy_r : dy_r;

  ocov_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dx_abs[MAG_W-1:0]),
    .divisor  (count_new),
    .quotient (qx),
    .busy     (busy_x)
  );

  ocov_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dy_abs[MAG_W-1:0]),
    .divisor  (count_new),
    .quotient (qy),
    .busy     (busy_y)
  );

  assign stat.div_done = !busy_x && !busy_y;

  // New means: old mean plus the signed quotient, clamped to 32 bits.
  always_comb begin
    qx_w  = $signed({{(MSUM_W-MAG_W){1'b0}}, qx});
    qy_w  = $signed({{(MSUM_W-MAG_W){1'b0}}, qy});
    qx_s  = dx_r[DIFF_W-1] ? -qx_w : qx_w;
    qy_s  = dy_r[DIFF_W-1] ? -qy_w : qy_w;
    sum_x = MSUM_W'(mean_x_r) + qx_s;
    sum_y = MSUM_W'(mean_y_r) + qy_s;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      SEL_CROSS: begin
        a_op = dx_r;
        b_op = DIFF_W'(ys_r) - DIFF_W'(nmy_r);
      end
      SEL_SPX: begin
        a_op = dx_r;
        b_op = DIFF_W'(xs_r) - DIFF_W'(nmx_r);
      end
      SEL_SPY: begin
        a_op = dy_r;
        b_op = DIFF_W'(ys_r) - DIFF_W'(nmy_r);
      end
      default: begin
        a_op = dx_r;
        b_op = dy_r;
      end
    endcase
    a_abs  = a_op[DIFF_W-1] ? -a_op : a_op;
    b_abs  = b_op[DIFF_W-1] ? -b_op : b_op;
    a_mag  = a_abs[MAG_W-1:0];
    b_mag  = b_abs[MAG_W-1:0];
    prod_w = a_mag * b_mag;
  end

  // Saturating add of the registered product into the selected moment.
  always_comb begin
    case (cmd.acc_sel)
      SEL_CROSS: old_acc = cross_r;
      SEL_SPX:   old_acc = $signed({1'b0, spread_x_r});
      SEL_SPY:   old_acc = $signed({1'b0, spread_y_r});
      default:   old_acc = cross_r;
    endcase
    prod_ext   = $signed({{(SUM_W-PROD_W){1'b0}}, prod_r});
    acc_sum    = neg_r ? SUM_W'(old_acc) - prod_ext : SUM_W'(old_acc) + prod_ext;
    acc_sat    = clamp_acc(acc_sum);
    spread_new = acc_sat[ACC_W-1] ? '0 : acc_sat[SPREAD_W-1:0];
  end

  // Working registers for one request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r <= xs_in;
      ys_r <= ys_in;
      dx_r <= dx_in;
      dy_r <= dy_in;
    end
    if (cmd.mean_load) begin
      nmx_r <= clamp_mean(sum_x);
      nmy_r <= clamp_mean(sum_y);
    end
    if (cmd.mul_en) begin
      prod_r <= prod_w;
      neg_r  <= a_op[DIFF_W-1] ^ b_op[DIFF_W-1];
    end
    if (cmd.acc_en) begin
      case (cmd.acc_sel)
        SEL_CROSS: ncross_r <= acc_sat;
        SEL_SPX:   nspx_r   <= spread_new;
        SEL_SPY:   nspy_r   <= spread_new;
        default:   ncross_r <= ncross_r;
      endcase
    end
  end

  // Committed statistics update all at once when the result is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      mean_x_r   <= '0;
      mean_y_r   <= '0;
      cross_r    <= '0;
      spread_x_r <= '0;
      spread_y_r <= '0;
    end else if (cmd.commit) begin
      count_r    <= count_new;
      mean_x_r   <= nmx_r;
      mean_y_r   <= nmy_r;
      cross_r    <= ncross_r;
      spread_x_r <= nspx_r;
      spread_y_r <= nspy_r;
    end
  end

  // The committed statistics are the result payload.
  always_comb begin
    cnt_wide              = CNT_WIDE_W'(count_r);
    out_data.sample_count = (cnt_wide > CNT_WIDE_W'({CNT_OUT_W{1'b1}}))
                            ? {CNT_OUT_W{1'b1}} : cnt_wide[CNT_OUT_W-1:0];
    out_data.mean_of_x    = mean_x_r;
    out_data.mean_of_y    = mean_y_r;
    out_data.cross_moment = cross_r;
    out_data.spread_of_x  = spread_x_r;
    out_data.spread_of_y  = spread_y_r;
  end

endmodule

`default_nettype wire

// File: src/ocov_ctrl.sv
// Controller state machine: sequences load, divide, mean update,
// three multiply-accumulate steps and commit. Depends on ocov_pkg.
`default_nettype none

module ocov_ctrl import ocov_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t                 state_r, state_nxt;
  logic [MUL_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // State, step counter and result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mul_sel = SEL_CROSS;
    cmd.acc_sel = SEL_CROSS;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cmd.mean_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        // Multiply step n overlaps the accumulate of step n-1.
        cmd.mul_en = (cnt_r != MUL_LAST);
        cmd.acc_en = (cnt_r != '0);
        if (cnt_r != MUL_LAST) begin
          cmd.mul_sel = mom_sel_t'(cnt_r);
        end
        if (cnt_r != '0) begin
          cmd.acc_sel = mom_sel_t'(cnt_r - MUL_CNT_W'(1));
        end
        cnt_nxt = cnt_r + MUL_CNT_W'(1);
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // Wait until the previous result has been taken.
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid is set on commit and cleared when the result is taken.
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: src/ocov_checker.sv
// Port-level assertions for the online covariance accumulator, bound to the top.
// Depends on ocov_pkg and online_covariance_accumulator.
`default_nettype none

module ocov_checker import ocov_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before acceptance");

  // A pending result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in work");

  // A new result appears only after a request has finished its work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result offered without a request in work");

  // Every result counts at least one sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sample_count != '0)
    else $error("result with zero sample count");

endmodule

bind online_covariance_accumulator ocov_checker u_ocov_checker (.*);

`default_nettype wire

// File: bench/tb_online_covariance_accumulator.sv
// Self-checking bench for online_covariance_accumulator: random and directed sample pairs,
// predicted Welford statistics compared field by field with each result request.
// Depends on ocov_pkg and the online_covariance_accumulator RTL.
`timescale 1ns / 100ps

module tb_online_covariance_accumulator;
  import ocov_pkg::*;

  localparam int N_PAIRS       = 1600;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 500;
  localparam int HOLD_AFTER    = 300;

  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint      MEAN_ONE  = longint'(1) << FRAC_BITS;
  localparam longint      MOM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint      MOM_MIN   = 64'sh8000_0000_0000_0000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  online_covariance_accumulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Sample pairs waiting to be offered, and statistics still owed by the block.
  in_t  pending_pairs[$];
  out_t expected_stats[$];

  // Running statistics as the block should hold them.
  logic [63:0] run_count    = '0;
  longint      run_mean_x   = 0;
  longint      run_mean_y   = 0;
  longint      run_cross    = 0;
  longint      run_spread_x = 0;
  longint      run_spread_y = 0;

  int   n_accepted   = 0;
  int   n_checked    = 0;
  int   n_directed   = 0;
  int   mismatches   = 0;
  int   cross_limits = 0;
  int   spread_sats  = 0;
  int   idle_cycles  = 0;
  logic in_taken     = 1'b0;

  // Accumulate a*b onto acc with the product taken at full width, saturating to 64 bits.
  function automatic longint sat_mac(longint acc, longint a, longint b);
    logic signed [129:0] wa;
    logic signed [129:0] wb;
    logic signed [129:0] total;
    wa    = a;
    wb    = b;
    total = wa * wb;
    total = total + acc;
    if (!total[129] && (|total[128:63])) return MOM_MAX;
    if (total[129] && !(&total[128:63])) return MOM_MIN;
    return longint'(total[63:0]);
  endfunction

  function automatic longint clamp_mean(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < -longint'(64'h8000_0000)) return -longint'(64'h8000_0000);
    return v;
  endfunction

  // One Welford step on the running statistics; returns the updated values.
  function automatic out_t welford_update(in_t pair);
    longint xs;
    longint ys;
    longint dx;
    longint dy;
    longint new_mx;
    longint new_my;
    out_t   r;
    xs = longint'(pair.sample_x) * MEAN_ONE;
    ys = longint'(pair.sample_y) * MEAN_ONE;
    if (run_count < COUNT_MAX) run_count++;
    dx = xs - run_mean_x;
    dy = ys - run_mean_y;
    // Division of signed integers truncates toward zero.
    new_mx = clamp_mean(run_mean_x + dx / longint'(run_count));
    new_my = clamp_mean(run_mean_y + dy / longint'(run_count));
    // The cross moment uses the new y mean; each spread uses old and new means.
    run_cross    = sat_mac(run_cross, dx, ys - new_my);
    run_spread_x = sat_mac(run_spread_x, dx, xs - new_mx);
    if (run_spread_x < 0) run_spread_x = 0;
    run_spread_y = sat_mac(run_spread_y, dy, ys - new_my);
    if (run_spread_y < 0) run_spread_y = 0;
    run_mean_x = new_mx;
    run_mean_y = new_my;
    if (run_cross == MOM_MAX || run_cross == MOM_MIN) cross_limits++;
    if (run_spread_x == MOM_MAX || run_spread_y == MOM_MAX) spread_sats++;
    r.sample_count = (run_count > 64'hFFFF_FFFF) ? '1 : CNT_OUT_W'(run_count);
    r.mean_of_x    = MEAN_W'(run_mean_x);
    r.mean_of_y    = MEAN_W'(run_mean_y);
    r.cross_moment = ACC_W'(run_cross);
    r.spread_of_x  = SPREAD_W'(run_spread_x);
    r.spread_of_y  = SPREAD_W'(run_spread_y);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_pair(input int x, input int y);
    in_t p;
    p.sample_x = SAMPLE_W'(x);
    p.sample_y = SAMPLE_W'(y);
    pending_pairs.push_back(p);
  endtask

  // Mostly small values near zero, with full-range values and the extremes mixed in.
  function automatic int draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($signed(16'($urandom)));
      4: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 600)) - 300;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
  endtask

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    out_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_stats.push_back(welford_update(in_data));
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          $error("result request with no request outstanding");
          mismatches++;
        end else begin
          want = expected_stats.pop_front();
          check_field("sample_count", 64'(want.sample_count), 64'(out_data.sample_count));
          check_field("mean_of_x", 64'(want.mean_of_x), 64'(out_data.mean_of_x));
          check_field("mean_of_y", 64'(want.mean_of_y), 64'(out_data.mean_of_y));
          check_field("cross_moment", 64'(want.cross_moment), 64'(out_data.cross_moment));
          check_field("spread_of_x", 64'(want.spread_of_x), 64'(out_data.spread_of_x));
          check_field("spread_of_y", 64'(want.spread_of_y), 64'(out_data.spread_of_y));
        end
        n_checked++;
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // The current request has not been taken yet; hold it.
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_pairs.size() != 0) begin
      in_data  <= pending_pairs.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a 16-bit ready pattern reused for a few rounds, plus one long hold-off.
  logic [15:0] ready_mask  = '1;
  int          mask_pos    = 0;
  int          mask_rounds = 0;
  int          hold_left   = 0;
  logic        hold_done   = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_done && n_checked >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_mask[mask_pos];
      if (mask_pos != 15) begin
        mask_pos <= mask_pos + 1;
      end else begin
        mask_pos <= 0;
        if (mask_rounds > 0) begin
          mask_rounds <= mask_rounds - 1;
        end else begin
          mask_rounds <= $urandom_range(0, 7);
          case ($urandom_range(0, 3))
            0: ready_mask <= '1;
            1: ready_mask <= 16'($urandom);
            2: ready_mask <= 16'($urandom | $urandom);
            default: ready_mask <= 16'($urandom & $urandom);
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("online_covariance_accumulator: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pairs: zero, opposite extremes, unit steps, truncation of small deviations.
    add_pair(0, 0);
    add_pair(32767, -32768);
    add_pair(-32768, 32767);
    add_pair(-1, 1);
    add_pair(1, -1);
    add_pair(3, -3);
    repeat (3) add_pair(-5, 7);
    // Extremes moving together drive the spreads and the cross moment to the top limit.
    for (int i = 0; i < 6; i++) begin
      add_pair((i % 2) ? 32767 : -32768, (i % 2) ? 32767 : -32768);
    end
    // Extremes moving apart pull the cross moment down to the bottom limit.
    for (int i = 0; i < 8; i++) begin
      add_pair((i % 2) ? 32767 : -32768, (i % 2) ? -32768 : 32767);
    end
    n_directed = pending_pairs.size();

    // Sender pauses here until every outstanding result has come back.
    wait_drained();

    for (int i = n_directed; i < N_PAIRS; i++) begin
      add_pair(draw_sample(), draw_sample());
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d sample pairs (%0d directed) and checked %0d results.",
             n_accepted, n_directed, n_checked);
    $display("Cross moment sat at a limit on %0d updates, a spread on %0d updates.",
             cross_limits, spread_sats);
    if (mismatches == 0) begin
      $display("online_covariance_accumulator: match");
    end else begin
      $display("online_covariance_accumulator: mismatch");
    end
    $finish;
  end

endmodule
